>>> rtl/bpc_pkg.sv
// package for the barometric pressure compensation block
// register indexes, widths and shared types; no dependencies
package bpc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    RegTrimT1   = 3'd0,
    RegTrimT2T3 = 3'd1,
    RegTrimP1   = 3'd2,
    RegTrimP2P3 = 3'd3,
    RegTrimP4P5 = 3'd4,
    RegTrimP6P7 = 3'd5,
    RegTrimP8P9 = 3'd6,
    RegNone     = 3'd7
  } reg_idx_e;

  localparam int unsigned DivW = 64;
  localparam int unsigned DivStages = 64;

endpackage

>>> rtl/barometric_pressure_compensation_top.sv
// top level of the barometric pressure compensation block
// uses bpc_pkg; pipelined datapath with a one-bit-per-stage restoring divider
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------------
//   command  | start_i / busy_o   | raw_pressure_i, raw_temperature_i
//   result   | done_o (strobe)    | pressure_q24_8_o, fine_temperature_o,
//            |                    | divide_error_o
//   config   | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// one sample is accepted every cycle; busy_o stays low
// each sample flows through the front stages, the 64-stage divider and the post stages
// reset clears the trim registers and all stage valid bits
// the receiver cannot stall, so the pipeline always advances
module barometric_pressure_compensation_top
  import bpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [19:0]         raw_pressure_i,
  input  logic [19:0]         raw_temperature_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                done_o,
  output logic [31:0]         pressure_q24_8_o,
  output logic signed [31:0]  fine_temperature_o,
  output logic                divide_error_o
);

  // trim registers
  logic [15:0] t1_q, p1_q;
  logic [31:0] t23_q, p23_q, p45_q, p67_q, p89_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0; p1_q <= '0; t23_q <= '0; p23_q <= '0;
      p45_q <= '0; p67_q <= '0; p89_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegTrimT1:   t1_q  <= cfg_data_i[15:0];
        RegTrimT2T3: t23_q <= cfg_data_i;
        RegTrimP1:   p1_q  <= cfg_data_i[15:0];
        RegTrimP2P3: p23_q <= cfg_data_i;
        RegTrimP4P5: p45_q <= cfg_data_i;
        RegTrimP6P7: p67_q <= cfg_data_i;
        RegTrimP8P9: p89_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [31:0] t2, t3;
  logic signed [63:0] p2, p3, p4, p5, p6, p7, p8, p9, p1s;
  assign t2  = 32'(signed'(t23_q[15:0]));
  assign t3  = 32'(signed'(t23_q[31:16]));
  assign p2  = 64'(signed'(p23_q[15:0]));
  assign p3  = 64'(signed'(p23_q[31:16]));
  assign p4  = 64'(signed'(p45_q[15:0]));
  assign p5  = 64'(signed'(p45_q[31:16]));
  assign p6  = 64'(signed'(p67_q[15:0]));
  assign p7  = 64'(signed'(p67_q[31:16]));
  assign p8  = 64'(signed'(p89_q[15:0]));
  assign p9  = 64'(signed'(p89_q[31:16]));
  assign p1s = {48'd0, p1_q};

  assign busy_o = 1'b0;

  localparam int unsigned Pre = 8;
  logic [Pre-1:0] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else v_q <= {v_q[Pre-2:0], start_i};
  end

  // stage 1: temperature differences
  logic signed [31:0] s1_d1_q, s1_d2_q;
  logic [19:0] s1_adcp_q;
  always_ff @(posedge clk_i) begin
    s1_d1_q   <= 32'({12'd0, raw_temperature_i[19:3]}) - 32'({t1_q, 1'b0});
    s1_d2_q   <= 32'({12'd0, raw_temperature_i[19:4]}) - 32'(t1_q);
    s1_adcp_q <= raw_pressure_i;
  end

  // stage 2: first products
  logic signed [31:0] s2_v1_q, s2_sq_q;
  logic [19:0] s2_adcp_q;
  always_ff @(posedge clk_i) begin
    s2_v1_q   <= (s1_d1_q * t2) >>> 11;
    s2_sq_q   <= (s1_d2_q * s1_d2_q) >>> 12;
    s2_adcp_q <= s1_adcp_q;
  end

  // stage 3: fine temperature
  logic signed [31:0] s3_tf_q;
  logic [19:0] s3_adcp_q;
  logic signed [31:0] v2;
  assign v2 = (s2_sq_q * t3) >>> 14;
  always_ff @(posedge clk_i) begin
    s3_tf_q   <= s2_v1_q + v2;
    s3_adcp_q <= s2_adcp_q;
  end

  // stage 4: offset temperature, fits in 33 bits
  logic signed [32:0] s4_a_q;
  logic signed [31:0] s4_tf_q;
  logic [19:0] s4_adcp_q;
  always_ff @(posedge clk_i) begin
    s4_a_q    <= 33'(s3_tf_q) - 33'sd128000;
    s4_tf_q   <= s3_tf_q;
    s4_adcp_q <= s3_adcp_q;
  end

  // stage 5: square and linear terms
  logic signed [63:0] s5_aa_q, s5_ap5_q, s5_ap2_q;
  logic signed [31:0] s5_tf_q;
  logic [19:0] s5_adcp_q;
  always_ff @(posedge clk_i) begin
    s5_aa_q   <= 64'(s4_a_q) * 64'(s4_a_q);
    s5_ap5_q  <= (64'(s4_a_q) * p5) <<< 17;
    s5_ap2_q  <= (64'(s4_a_q) * p2) <<< 12;
    s5_tf_q   <= s4_tf_q;
    s5_adcp_q <= s4_adcp_q;
  end

  // stage 6: quadratic terms
  logic signed [63:0] s6_b_q, s6_a_q;
  logic signed [31:0] s6_tf_q;
  logic [19:0] s6_adcp_q;
  always_ff @(posedge clk_i) begin
    s6_b_q    <= s5_aa_q * p6 + s5_ap5_q + (p4 <<< 35);
    s6_a_q    <= ((s5_aa_q * p3) >>> 8) + s5_ap2_q;
    s6_tf_q   <= s5_tf_q;
    s6_adcp_q <= s5_adcp_q;
  end

  // stage 7: divisor and numerator base
  logic signed [63:0] s7_div_q, s7_num_q;
  logic signed [31:0] s7_tf_q;
  logic signed [63:0] pb;
  assign pb = 64'sd1048576 - 64'(s6_adcp_q);
  always_ff @(posedge clk_i) begin
    s7_div_q <= ((64'sh0000_8000_0000_0000 + s6_a_q) * p1s) >>> 33;
    s7_num_q <= (pb <<< 31) - s6_b_q;
    s7_tf_q  <= s6_tf_q;
  end

  // stage 8: numerator scale, operand signs and magnitudes
  logic [63:0] s8_n_q, s8_d_q;
  logic s8_neg_q, s8_err_q;
  logic signed [31:0] s8_tf_q;
  logic signed [63:0] numx;
  assign numx = s7_num_q * 64'sd3125;
  always_ff @(posedge clk_i) begin
    s8_n_q   <= numx[63] ? 64'(-numx) : numx;
    s8_d_q   <= s7_div_q[63] ? 64'(-s7_div_q) : s7_div_q;
    s8_neg_q <= numx[63] ^ s7_div_q[63];
    s8_err_q <= (s7_div_q == '0);
    s8_tf_q  <= s7_tf_q;
  end

  // restoring divider, one quotient bit per stage
  localparam int unsigned DivLast = DivStages - 1;
  logic [DivW-1:0]    dv_r   [DivStages];
  logic [DivW-1:0]    dv_n   [DivStages];
  logic [DivW-1:0]    dv_d   [DivStages];
  logic               dv_v   [DivStages];
  logic               dv_neg [DivStages];
  logic               dv_err [DivStages];
  logic signed [31:0] dv_tf  [DivStages];

  for (genvar k = 0; k < DivStages; k++) begin : g_div
    logic [DivW-1:0] r_in, n_in, d_in;
    logic v_in, neg_in, err_in;
    logic signed [31:0] tf_in;
    logic [DivW:0] trial, diff;
    if (k == 0) begin : g_head
      assign r_in   = '0;
      assign n_in   = s8_n_q;
      assign d_in   = s8_d_q;
      assign v_in   = v_q[Pre-1];
      assign neg_in = s8_neg_q;
      assign err_in = s8_err_q;
      assign tf_in  = s8_tf_q;
    end else begin : g_body
      assign r_in   = dv_r[k-1];
      assign n_in   = dv_n[k-1];
      assign d_in   = dv_d[k-1];
      assign v_in   = dv_v[k-1];
      assign neg_in = dv_neg[k-1];
      assign err_in = dv_err[k-1];
      assign tf_in  = dv_tf[k-1];
    end
    assign trial = {r_in, n_in[DivW-1]};
    assign diff  = trial - {1'b0, d_in};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v[k] <= 1'b0;
      else dv_v[k] <= v_in;
    end
    always_ff @(posedge clk_i) begin
      dv_r[k]   <= diff[DivW] ? trial[DivW-1:0] : diff[DivW-1:0];
      dv_n[k]   <= {n_in[DivW-2:0], ~diff[DivW]};
      dv_d[k]   <= d_in;
      dv_neg[k] <= neg_in;
      dv_err[k] <= err_in;
      dv_tf[k]  <= tf_in;
    end
  end

  // post stage 1: signed quotient
  logic signed [63:0] q1_p_q;
  logic q1_v_q, q1_err_q;
  logic signed [31:0] q1_tf_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) q1_v_q <= 1'b0;
    else q1_v_q <= dv_v[DivLast];
  end
  always_ff @(posedge clk_i) begin
    q1_p_q   <= dv_neg[DivLast] ? 64'(-dv_n[DivLast]) : dv_n[DivLast];
    q1_err_q <= dv_err[DivLast];
    q1_tf_q  <= dv_tf[DivLast];
  end

  // post stage 2: scaled quotient, p8 and p9 products
  logic signed [63:0] q2_p_q, q2_q_q, q2_p8_q, q2_p9q_q;
  logic q2_v_q, q2_err_q;
  logic signed [31:0] q2_tf_q;
  logic signed [63:0] qs;
  assign qs = q1_p_q >>> 13;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) q2_v_q <= 1'b0;
    else q2_v_q <= q1_v_q;
  end
  always_ff @(posedge clk_i) begin
    q2_p_q   <= q1_p_q;
    q2_q_q   <= qs;
    q2_p8_q  <= (p8 * q1_p_q) >>> 19;
    q2_p9q_q <= p9 * qs;
    q2_err_q <= q1_err_q;
    q2_tf_q  <= q1_tf_q;
  end

  // post stage 3: low 64 bits of p9q times q from 32-bit halves
  logic [63:0] q3_ll_q;
  logic [31:0] q3_mid_q;
  logic signed [63:0] q3_p_q, q3_p8_q;
  logic q3_v_q, q3_err_q;
  logic signed [31:0] q3_tf_q;
  logic [31:0] xl, xh, yl, yh;
  assign xl = q2_p9q_q[31:0];
  assign xh = q2_p9q_q[63:32];
  assign yl = q2_q_q[31:0];
  assign yh = q2_q_q[63:32];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) q3_v_q <= 1'b0;
    else q3_v_q <= q2_v_q;
  end
  always_ff @(posedge clk_i) begin
    q3_ll_q  <= 64'(xl) * 64'(yl);
    q3_mid_q <= xh * yl + xl * yh;
    q3_p_q   <= q2_p_q;
    q3_p8_q  <= q2_p8_q;
    q3_err_q <= q2_err_q;
    q3_tf_q  <= q2_tf_q;
  end

  // post stage 4: cubic term and sum
  logic signed [63:0] q4_sum_q;
  logic q4_v_q, q4_err_q;
  logic signed [31:0] q4_tf_q;
  logic [63:0] prod;
  logic signed [63:0] aq;
  assign prod = q3_ll_q + {q3_mid_q, 32'd0};
  assign aq   = $signed(prod) >>> 25;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) q4_v_q <= 1'b0;
    else q4_v_q <= q3_v_q;
  end
  always_ff @(posedge clk_i) begin
    q4_sum_q <= q3_p_q + aq + q3_p8_q;
    q4_err_q <= q3_err_q;
    q4_tf_q  <= q3_tf_q;
  end

  // post stage 5: final scaling, result register
  logic signed [63:0] fin;
  assign fin = (q4_sum_q >>> 8) + (p7 <<< 4);
  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= q4_v_q;
  end
  always_ff @(posedge clk_i) begin
    pressure_q24_8_o   <= q4_err_q ? 32'd0 : fin[31:0];
    divide_error_o     <= q4_err_q;
    fine_temperature_o <= q4_tf_q;
  end
  assign done_o = done_q;

endmodule

>>> tb/sv/tb_barometric_pressure_compensation_top.sv
// testbench for the barometric pressure compensation block
// drives raw samples and trim writes, predicts each result and checks it in order
// depends on bpc_pkg and barometric_pressure_compensation_top
`timescale 1ns / 1ps

module tb_barometric_pressure_compensation_top
  import bpc_pkg::*;
();

  localparam int unsigned Latency = 8 + 64 + 5;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [31:0] pressure;
    logic [31:0] tfine;
    logic        div_err;
  } comp_result_t;

  // expected compensation results in acceptance order
  class comp_scoreboard;
    logic [31:0]  trim [7];
    comp_result_t pending [$];
    int unsigned  mismatches;

    function void write_trim(reg_idx_e idx, logic [31:0] data);
      if (idx == RegTrimT1 || idx == RegTrimP1) data = data & 32'hffff;
      if (idx != RegNone) trim[idx] = data;
    endfunction

    function automatic logic signed [63:0] sx16(logic [15:0] v);
      return {{48{v[15]}}, v};
    endfunction

    // compensation datapath, 32-bit wrap for tfine, 64-bit wrap for pressure
    function automatic comp_result_t compensate(logic [19:0] adc_p, logic [19:0] adc_t);
      comp_result_t r;
      logic signed [31:0] t1, t2, t3, d1, d2, v1, v2, tf;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, p, q;
      t1 = {16'd0, trim[RegTrimT1][15:0]};
      t2 = {{16{trim[RegTrimT2T3][15]}}, trim[RegTrimT2T3][15:0]};
      t3 = {{16{trim[RegTrimT2T3][31]}}, trim[RegTrimT2T3][31:16]};
      p1 = {48'd0, trim[RegTrimP1][15:0]};
      p2 = sx16(trim[RegTrimP2P3][15:0]); p3 = sx16(trim[RegTrimP2P3][31:16]);
      p4 = sx16(trim[RegTrimP4P5][15:0]); p5 = sx16(trim[RegTrimP4P5][31:16]);
      p6 = sx16(trim[RegTrimP6P7][15:0]); p7 = sx16(trim[RegTrimP6P7][31:16]);
      p8 = sx16(trim[RegTrimP8P9][15:0]); p9 = sx16(trim[RegTrimP8P9][31:16]);
      d1 = $signed({15'd0, adc_t[19:3]}) - (t1 <<< 1);
      v1 = (d1 * t2) >>> 11;
      d2 = $signed({16'd0, adc_t[19:4]}) - t1;
      v2 = (((d2 * d2) >>> 12) * t3) >>> 14;
      tf = v1 + v2;
      r.tfine = tf;
      a = 64'(tf) - 64'sd128000;
      b = a * a * p6;
      b = b + ((a * p5) <<< 17);
      b = b + (p4 <<< 35);
      a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
      a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
      if (a == 0) begin
        r.pressure = '0;
        r.div_err = 1'b1;
        return r;
      end
      p = 64'sd1048576 - $signed({44'd0, adc_p});
      p = ((p <<< 31) - b) * 64'sd3125;
      // most negative over minus one wraps; SV division truncates toward zero
      if (a == -64'sd1) p = -p;
      else p = p / a;
      q = p >>> 13;
      a = (p9 * q * q) >>> 25;
      b = (p8 * p) >>> 19;
      p = ((p + a + b) >>> 8) + (p7 <<< 4);
      r.pressure = p[31:0];
      r.div_err = 1'b0;
      return r;
    endfunction

    function void note_sample(logic [19:0] adc_p, logic [19:0] adc_t);
      pending.push_back(compensate(adc_p, adc_t));
    endfunction

    function void check_result(comp_result_t got);
      comp_result_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got.pressure !== exp_r.pressure || got.tfine !== exp_r.tfine ||
          got.div_err !== exp_r.div_err) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp p=%h t=%h e=%b got p=%h t=%h e=%b",
                   exp_r.pressure, exp_r.tfine, exp_r.div_err,
                   got.pressure, got.tfine, got.div_err);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [19:0] raw_pressure_i = '0;
  logic [19:0] raw_temperature_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic        done_o;
  logic [31:0] pressure_q24_8_o;
  logic signed [31:0] fine_temperature_o;
  logic        divide_error_o;

  comp_scoreboard sb = new();
  int unsigned cycle_count = 0;
  bit calm = 1'b0;

  barometric_pressure_compensation_top u_top (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result monitor and run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && done_o)
      sb.check_result({pressure_q24_8_o, fine_temperature_o, divide_error_o});
    if (cycle_count > CycleLimit) begin
      $display("[barometric_pressure_compensation_top] ERROR");
      $finish;
    end
  end

  // write enable stays high; the caller drops it after the last write
  task automatic write_trim_reg(reg_idx_e idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_trim(idx, data);
    @(negedge clk_i);
  endtask

  // one transaction, random idle cycles unless in the calm stretch
  task automatic send_sample(logic [19:0] adc_p, logic [19:0] adc_t);
    while (!calm && $urandom_range(99) < 38) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    raw_pressure_i <= adc_p;
    raw_temperature_i <= adc_t;
    do @(posedge clk_i); while (busy_o);
    sb.note_sample(adc_p, adc_t);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic load_trims(logic [31:0] t1, logic [31:0] t23, logic [31:0] p1,
                            logic [31:0] p23, logic [31:0] p45, logic [31:0] p67,
                            logic [31:0] p89);
    write_trim_reg(RegTrimT1, t1);
    write_trim_reg(RegTrimT2T3, t23);
    write_trim_reg(RegTrimP1, p1);
    write_trim_reg(RegTrimP2P3, p23);
    write_trim_reg(RegTrimP4P5, p45);
    write_trim_reg(RegTrimP6P7, p67);
    write_trim_reg(RegTrimP8P9, p89);
    cfg_we_i <= 1'b0;
  endtask

  // realistic trim set with small random disturbance
  task automatic load_typical();
    load_trims(27504 + $urandom_range(200), {16'($signed(-1000)), 16'd26435},
               36477 + $urandom_range(200), {16'd3024, 16'($signed(-10685))},
               {16'd140, 16'd2855}, {16'd15500, 16'($signed(-7))},
               {16'd4000, 16'($signed(-14600))});
  endtask

  function automatic logic [19:0] typical_p();
    return 20'($urandom_range(200000, 500000));
  endfunction

  function automatic logic [19:0] typical_t();
    return 20'($urandom_range(400000, 600000));
  endfunction

  initial begin
    for (int i = 0; i < 7; i++) sb.trim[i] = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset trims: divisor is zero
    send_sample(20'h00000, 20'h00000);
    send_sample(20'hfffff, 20'hfffff);
    drain();

    // unknown index is ignored
    write_trim_reg(RegNone, 32'hdeadbeef);
    load_typical();
    calm = 1'b1;
    send_sample(20'h00000, 20'h00000);
    send_sample(20'hfffff, 20'hfffff);
    send_sample(20'h80000, 20'h7ffff);
    send_sample(20'h55555, 20'haaaaa);
    send_sample(20'haaaaa, 20'h55555);
    send_sample(typical_p(), typical_t());
    calm = 1'b0;
    drain();

    // extreme trims, wrap everywhere
    load_trims(32'hffff, 32'h80008000, 32'hffff, 32'h7fff8000,
               32'h80007fff, 32'h7fff7fff, 32'h80008000);
    send_sample(20'h00000, 20'hfffff);
    send_sample(20'hfffff, 20'h00000);
    send_sample(20'h12345, 20'h54321);
    drain();
    load_trims(32'h0, 32'hffffffff, 32'h1, 32'hffffffff,
               32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_sample(20'h00000, 20'h00000);
    send_sample(20'hfffff, 20'hfffff);
    drain();
    // small nonzero divisor: p1 of one with a zero a term
    load_trims(32'h0, 32'h0, 32'h1, 32'h00000000, 32'h0, 32'h0, 32'h0);
    send_sample(20'h00100, 20'h00100);
    drain();

    // random phases: mostly realistic trims, some fully random
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 2)
        load_trims($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        load_typical();
      calm = (ph == 4);
      for (int n = 0; n < 64; n++) begin
        if ($urandom_range(9) < 7) send_sample(typical_p(), typical_t());
        else send_sample(20'($urandom), 20'($urandom));
      end
      calm = 1'b0;
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("[barometric_pressure_compensation_top] OK");
    else
      $display("[barometric_pressure_compensation_top] ERROR");
    $finish;
  end

endmodule
